// File: rtl/interface_address_table_defines.svh
// ----------------------------------------------------------------------------
// Interface address table: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INTERFACE_ADDRESS_TABLE_DEFINES_SVH
`define INTERFACE_ADDRESS_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define IAT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("interface address table assertion failed");
`define IAT_ASSERT_NEXT(lbl, clk, rstn, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) \
        else $error("interface address table sequence check failed");
`else
`define IAT_ASSERT(lbl, clk, rstn, prop)
`define IAT_ASSERT_NEXT(lbl, clk, rstn, cond, nxt)
`endif

`endif

// File: rtl/iat_pkg.sv
// ----------------------------------------------------------------------------
// Interface address table package
// Sizes, codes, entry layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package iat_pkg;

    localparam int ENTRIES    = 16;
    localparam int IF_ID_BITS = 8;

    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ID_W       = IF_ID_BITS;
    localparam int ACT_W      = 2;
    localparam int FAM_W      = 2;
    localparam int PFX_W      = 8;
    localparam int ADDR_W     = 64;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 4;

    localparam int S_TDATA_W  = 144;
    localparam int S_TUSER_W  = 4;
    localparam int M_TDATA_W  = 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_INVALID_IF_ID = 1'b0;
    localparam logic [ID_W-1:0] INVALID_IF_ID_RESET = ID_W'(8'hFF);

    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

    localparam logic [FAM_W-1:0] FAM_UNSPEC = 2'd0;
    localparam logic [FAM_W-1:0] FAM_IPV4   = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVAL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] SEL_ZERO  = 2'd0;
    localparam logic [1:0] SEL_MATCH = 2'd1;
    localparam logic [1:0] SEL_FREE  = 2'd2;

    localparam logic [ADDR_W-1:0] V4_MASK = 64'hFFFF_FFFF_0000_0000;

    typedef struct packed {
        logic [ID_W-1:0]   if_id;
        logic [FAM_W-1:0]  family;
        logic [PFX_W-1:0]  pfx_len;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
    } entry_t;

    typedef struct packed {
        logic                capture;
        logic                scan_start;
        logic                scan_en;
        logic                latch_result;
        logic [STATUS_W-1:0] res_status;
        logic                res_hit;
        logic [1:0]          res_slot_sel;
        logic                write_entry;
        logic                clear_entry;
        logic                push_out;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             args_ok;
        logic             hit;
        logic             last;
        logic             free;
        logic             out_free;
    } stat_t;

endpackage

// File: rtl/iat_regs.sv
// ----------------------------------------------------------------------------
// Interface address table register block
// APB write/read of the invalid interface id register.
// ----------------------------------------------------------------------------
module iat_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [iat_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [iat_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [iat_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [iat_pkg::ID_W-1:0]          invalid_if_id
);

    logic [iat_pkg::ID_W-1:0]      invalid_if_id_reg;
    logic [iat_pkg::ID_W-1:0]      invalid_if_id_next;
    logic [iat_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[iat_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready
                     && (reg_idx == iat_pkg::REG_INVALID_IF_ID);

    always_comb begin
        invalid_if_id_next = invalid_if_id_reg;
        if (wr_en) begin
            invalid_if_id_next = pwdata[iat_pkg::ID_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invalid_if_id_reg <= iat_pkg::INVALID_IF_ID_RESET;
        end else begin
            invalid_if_id_reg <= invalid_if_id_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == iat_pkg::REG_INVALID_IF_ID) begin
            prdata = iat_pkg::APB_DATA_W'(invalid_if_id_reg);
        end
    end

    assign invalid_if_id = invalid_if_id_reg;

endmodule

// File: rtl/iat_ctrl.sv
// ----------------------------------------------------------------------------
// Interface address table controller
// Sequences capture, argument check, table scan, update and result transfer.
// ----------------------------------------------------------------------------
`include "interface_address_table_defines.svh"

module iat_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  iat_pkg::stat_t st,
    output iat_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       act_ok;

    assign s_tready = (state_reg == S_IDLE);
    assign act_ok   = (st.action == iat_pkg::ACT_ADD) || (st.action == iat_pkg::ACT_REMOVE)
                      || (st.action == iat_pkg::ACT_LOOKUP);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!act_ok) begin
                    cmd.latch_result = 1'b1;
                    cmd.res_status   = iat_pkg::ST_INVAL;
                    cmd.res_slot_sel = iat_pkg::SEL_ZERO;
                    state_next       = S_RESP;
                end else if (!st.args_ok) begin
                    cmd.latch_result = 1'b1;
                    cmd.res_status   = (st.action == iat_pkg::ACT_ADD) ?
                                       iat_pkg::ST_INVAL : iat_pkg::ST_NOTFOUND;
                    cmd.res_slot_sel = iat_pkg::SEL_ZERO;
                    state_next       = S_RESP;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (st.hit) begin
                    cmd.latch_result = 1'b1;
                    cmd.res_status   = iat_pkg::ST_OK;
                    cmd.res_hit      = (st.action != iat_pkg::ACT_ADD);
                    cmd.res_slot_sel = iat_pkg::SEL_MATCH;
                    cmd.clear_entry  = (st.action == iat_pkg::ACT_REMOVE);
                    state_next       = S_RESP;
                end else if (st.last) begin
                    cmd.latch_result = 1'b1;
                    state_next       = S_RESP;
                    if (st.action != iat_pkg::ACT_ADD) begin
                        cmd.res_status   = iat_pkg::ST_NOTFOUND;
                        cmd.res_slot_sel = iat_pkg::SEL_ZERO;
                    end else if (st.free) begin
                        cmd.res_status   = iat_pkg::ST_OK;
                        cmd.res_slot_sel = iat_pkg::SEL_FREE;
                        cmd.write_entry  = 1'b1;
                    end else begin
                        cmd.res_status   = iat_pkg::ST_NOSPACE;
                        cmd.res_slot_sel = iat_pkg::SEL_ZERO;
                    end
                end
            end
            S_RESP: begin
                if (st.out_free) begin
                    cmd.push_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `IAT_ASSERT_NEXT(a_accept_to_check, aclk, aresetn, s_tvalid && s_tready,
                     state_reg == S_CHECK)
    `IAT_ASSERT_NEXT(a_scan_continues, aclk, aresetn,
                     state_reg == S_SCAN && !st.hit && !st.last, state_reg == S_SCAN)
    `IAT_ASSERT_NEXT(a_resp_holds, aclk, aresetn, state_reg == S_RESP && !st.out_free,
                     state_reg == S_RESP)

endmodule

// File: rtl/iat_dp.sv
// ----------------------------------------------------------------------------
// Interface address table datapath
// Key capture, entry memory scan with compare, free slot tracking, valid
// bits, result and output registers.
// ----------------------------------------------------------------------------
`include "interface_address_table_defines.svh"

module iat_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [iat_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [iat_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic [iat_pkg::ID_W-1:0]         invalid_if_id,
    input  iat_pkg::cmd_t                    cmd,
    output iat_pkg::stat_t                   st,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [iat_pkg::M_TDATA_W-1:0]    m_tdata
);

    iat_pkg::entry_t mem [iat_pkg::ENTRIES];

    iat_pkg::entry_t                  key_reg;
    logic [iat_pkg::ACT_W-1:0]        action_reg;
    logic [iat_pkg::ENTRIES-1:0]      valid_reg;

    logic [iat_pkg::IDX_W-1:0]        scan_idx_reg;
    logic                             issue_reg;
    iat_pkg::entry_t                  rd_entry_reg;
    logic                             rd_vbit_reg;
    logic [iat_pkg::IDX_W-1:0]        rd_idx_reg;
    logic                             live_reg;
    logic                             free_found_reg;
    logic [iat_pkg::IDX_W-1:0]        free_idx_reg;

    logic [iat_pkg::STATUS_W-1:0]     res_status_reg;
    logic                             res_hit_reg;
    logic [iat_pkg::SLOT_W-1:0]       res_slot_reg;

    logic                             out_valid_reg;
    logic [iat_pkg::STATUS_W-1:0]     out_status_reg;
    logic                             out_hit_reg;
    logic [iat_pkg::SLOT_W-1:0]       out_slot_reg;

    iat_pkg::entry_t                  in_key;
    logic [iat_pkg::FAM_W-1:0]        in_family;
    logic                             match;
    logic                             free_now;
    logic [iat_pkg::IDX_W-1:0]        free_idx_now;
    logic [iat_pkg::SLOT_W-1:0]       res_slot_next;

    assign in_family = s_tuser[3:2];

    always_comb begin
        in_key.if_id      = s_tdata[iat_pkg::ID_W-1:0];
        in_key.family     = in_family;
        in_key.pfx_len    = s_tdata[15:8];
        if (in_family == iat_pkg::FAM_IPV4) begin
            in_key.addr_high = s_tdata[79:16] & iat_pkg::V4_MASK;
            in_key.addr_low  = '0;
        end else begin
            in_key.addr_high = s_tdata[79:16];
            in_key.addr_low  = s_tdata[143:80];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg    <= in_key;
            action_reg <= s_tuser[1:0];
        end
    end

    assign match        = live_reg && rd_vbit_reg && (rd_entry_reg == key_reg);
    assign free_now     = free_found_reg || (live_reg && !rd_vbit_reg);
    assign free_idx_now = free_found_reg ? free_idx_reg : rd_idx_reg;

    always_comb begin
        st.action   = action_reg;
        st.args_ok  = (key_reg.if_id != invalid_if_id)
                      && (key_reg.family != iat_pkg::FAM_UNSPEC);
        st.hit      = match;
        st.last     = live_reg && (rd_idx_reg == iat_pkg::IDX_W'(iat_pkg::ENTRIES - 1));
        st.free     = free_now;
        st.out_free = !out_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_entry) begin
            mem[free_idx_now] <= key_reg;
        end
        if (cmd.scan_en) begin
            rd_entry_reg <= mem[scan_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_en && issue_reg) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (cmd.scan_en) begin
            rd_idx_reg  <= scan_idx_reg;
            rd_vbit_reg <= valid_reg[scan_idx_reg];
        end
        if (cmd.scan_en && live_reg && !rd_vbit_reg && !free_found_reg) begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg      <= 1'b0;
            live_reg       <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            issue_reg      <= 1'b1;
            live_reg       <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.scan_en) begin
            live_reg <= issue_reg;
            if (issue_reg && (scan_idx_reg == iat_pkg::IDX_W'(iat_pkg::ENTRIES - 1))) begin
                issue_reg <= 1'b0;
            end
            if (live_reg && !rd_vbit_reg) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.write_entry) begin
            valid_reg[free_idx_now] <= 1'b1;
        end else if (cmd.clear_entry) begin
            valid_reg[rd_idx_reg] <= 1'b0;
        end
    end

    always_comb begin
        case (cmd.res_slot_sel)
            iat_pkg::SEL_MATCH: res_slot_next = iat_pkg::SLOT_W'(rd_idx_reg);
            iat_pkg::SEL_FREE:  res_slot_next = iat_pkg::SLOT_W'(free_idx_now);
            default:            res_slot_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_result) begin
            res_status_reg <= cmd.res_status;
            res_hit_reg    <= cmd.res_hit;
            res_slot_reg   <= res_slot_next;
        end
        if (cmd.push_out) begin
            out_status_reg <= res_status_reg;
            out_hit_reg    <= res_hit_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_slot_reg, out_hit_reg, out_status_reg};

    `IAT_ASSERT_NEXT(a_write_sets_valid, aclk, aresetn, cmd.write_entry,
                     valid_reg[$past(free_idx_now)])
    `IAT_ASSERT_NEXT(a_clear_drops_valid, aclk, aresetn, cmd.clear_entry,
                     !valid_reg[$past(rd_idx_reg)])
    `IAT_ASSERT(a_hit_means_ok, aclk, aresetn,
                cmd.latch_result && cmd.res_hit |-> cmd.res_status == iat_pkg::ST_OK)

endmodule

// File: rtl/interface_address_table.sv
// ----------------------------------------------------------------------------
// Interface address table
// Exact-match table of interface addresses with add, remove and lookup.
// ----------------------------------------------------------------------------
// Each request on the s_ stream yields exactly one response on the m_ stream.
// A request that reaches the table passes through capture, argument check, a
// scan of the entry memory one slot per cycle through its single read port,
// with the read data registered before the compare, then the response transfer
// into the output register. Requests rejected on their arguments and unknown
// actions skip the scan. One request is worked at a time; the output register
// lets the next request start while the previous response waits. The table is
// empty after reset with no clearing pass.
module interface_address_table (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] if_id, [15:8] pfx_len, [79:16] addr_high, [143:80] addr_low
    input  logic [iat_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] action, [3:2] family
    input  logic [iat_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] status, [2] hit, [6:3] slot, [7] zero
    output logic [iat_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [iat_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [iat_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [iat_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [iat_pkg::ID_W-1:0] invalid_if_id;
    iat_pkg::cmd_t            cmd;
    iat_pkg::stat_t           st;

    iat_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .invalid_if_id (invalid_if_id)
    );

    iat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    iat_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .invalid_if_id (invalid_if_id),
        .cmd           (cmd),
        .st            (st),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule
